/* src/fla_pkg.sv */
`default_nettype none
package fla_pkg;

    localparam int MEM_UNITS       = 1024;
    localparam int LEASE_SLOTS_DEF = 16;
    localparam int FREE_SLOTS_DEF  = 17;

    localparam int BASE_W  = $clog2(MEM_UNITS);
    localparam int LEN_W   = $clog2(MEM_UNITS + 1);
    localparam int SIZE_W  = 11;
    localparam int LEASE_W = 8;
    localparam int ADDR_W  = 10;
    localparam int EXP_W   = 5;
    localparam int TALLY_W = 16;
    localparam int CMP_W   = (LEN_W > SIZE_W) ? LEN_W : SIZE_W;

    localparam logic OP_TICK    = 1'b0;
    localparam logic OP_REQUEST = 1'b1;

    typedef struct packed {
        logic               operation;
        logic [SIZE_W-1:0]  request_size;
        logic [LEASE_W-1:0] lease_length;
    } t_in;

    typedef struct packed {
        logic               granted;
        logic [ADDR_W-1:0]  start_address;
        logic [EXP_W-1:0]   expired_count;
        logic [TALLY_W-1:0] request_total;
        logic [TALLY_W-1:0] satisfied_total;
        logic [TALLY_W-1:0] unsatisfied_total;
    } t_out;

    // one free range; an unused entry sorts after every used one
    typedef struct packed {
        logic              used;
        logic [BASE_W-1:0] base;
        logic [LEN_W-1:0]  len;
    } t_range;

    localparam t_range RANGE_HOLE = '0;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_SORT,
        CELL_MERGE
    } t_cell_op;

    typedef struct packed {
        t_cell_op op;
        logic     phase;
    } t_cell_ctl;

    typedef struct packed {
        logic odd;
        logic has_left;
        logic has_right;
    } t_cell_pos;

    function automatic logic [TALLY_W-1:0] sat_inc(input logic [TALLY_W-1:0] v);
        sat_inc = (v == '1) ? v : v + TALLY_W'(1);
    endfunction

endpackage
`default_nettype wire

/* src/fla_free_cell.sv */
`default_nettype none
module fla_free_cell (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  fla_pkg::t_cell_ctl i_ctl,
    input  fla_pkg::t_cell_pos i_pos,
    input  fla_pkg::t_range   i_rst_entry,
    input  fla_pkg::t_range   i_left,
    input  fla_pkg::t_range   i_right,
    input  logic              i_wr_en,
    input  fla_pkg::t_range   i_wr_entry,
    output fla_pkg::t_range   o_entry,
    output logic              o_merged
);
    import fla_pkg::*;

    t_range           r_entry;
    t_range           n_entry;
    t_range           w_partner;
    t_range           w_lo;
    t_range           w_hi;
    logic             w_is_left;
    logic             w_pair_ok;
    logic             w_swap;
    logic             w_adj;
    logic [LEN_W-1:0] w_lo_end;

    always_comb begin
        // pairs are (even,odd) in phase 0 and (odd,even) in phase 1
        w_is_left = (i_pos.odd == i_ctl.phase);
        w_partner = w_is_left ? i_right : i_left;
        w_pair_ok = w_is_left ? i_pos.has_right : i_pos.has_left;
        w_lo      = w_is_left ? r_entry : i_left;
        w_hi      = w_is_left ? i_right : r_entry;
        w_swap    = {~w_lo.used, w_lo.base} > {~w_hi.used, w_hi.base};
        w_lo_end  = LEN_W'(w_lo.base) + w_lo.len;
        w_adj     = w_lo.used & w_hi.used & (w_lo_end == LEN_W'(w_hi.base));
        n_entry   = r_entry;
        if (i_wr_en) begin
            n_entry = i_wr_entry;
        end else if (w_pair_ok) begin
            case (i_ctl.op)
                CELL_SORT: begin
                    if (w_swap) begin
                        n_entry = w_partner;
                    end
                end
                CELL_MERGE: begin
                    if (w_adj) begin
                        if (w_is_left) begin
                            n_entry.len = w_lo.len + w_hi.len;
                        end else begin
                            n_entry = RANGE_HOLE;
                        end
                    end
                end
                default: begin
                    n_entry = r_entry;
                end
            endcase
        end
        o_merged = w_pair_ok & w_is_left & (i_ctl.op == CELL_MERGE) & w_adj;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entry <= i_rst_entry;
        end else begin
            r_entry <= n_entry;
        end
    end

    assign o_entry = r_entry;

endmodule
`default_nettype wire

/* src/fla_free_table.sv */
`default_nettype none
module fla_free_table #(
    parameter int FREE_SLOTS = fla_pkg::FREE_SLOTS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  fla_pkg::t_cell_ctl            i_ctl,
    input  logic                          i_wr_en,
    input  logic [$clog2(FREE_SLOTS)-1:0] i_wr_idx,
    input  fla_pkg::t_range               i_wr_entry,
    input  logic [$clog2(FREE_SLOTS)-1:0] i_rd_idx,
    output fla_pkg::t_range               o_rd_entry,
    output logic                          o_full,
    output logic                          o_merged
);
    import fla_pkg::*;

    localparam int IDX_W = $clog2(FREE_SLOTS);

    t_range                w_cell  [FREE_SLOTS];
    t_range                w_left  [FREE_SLOTS];
    t_range                w_right [FREE_SLOTS];
    logic [FREE_SLOTS-1:0] w_mrg;

    for (genvar g = 0; g < FREE_SLOTS; g++) begin : g_cell
        t_cell_pos w_pos;
        t_range    w_rst;

        if (g == 0) begin : g_head
            assign w_left[g] = RANGE_HOLE;
            assign w_rst     = '{used: 1'b1, base: '0, len: LEN_W'(MEM_UNITS)};
        end else begin : g_body
            assign w_left[g] = w_cell[g-1];
            assign w_rst     = RANGE_HOLE;
        end

        if (g == FREE_SLOTS - 1) begin : g_tail
            assign w_right[g] = RANGE_HOLE;
        end else begin : g_mid
            assign w_right[g] = w_cell[g+1];
        end

        assign w_pos = '{odd: 1'((g % 2) == 1), has_left: 1'(g != 0),
                         has_right: 1'(g != FREE_SLOTS - 1)};

        fla_free_cell u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_ctl       (i_ctl),
            .i_pos       (w_pos),
            .i_rst_entry (w_rst),
            .i_left      (w_left[g]),
            .i_right     (w_right[g]),
            .i_wr_en     (i_wr_en && (i_wr_idx == IDX_W'(g))),
            .i_wr_entry  (i_wr_entry),
            .o_entry     (w_cell[g]),
            .o_merged    (w_mrg[g])
        );
    end

    assign o_rd_entry = w_cell[i_rd_idx];
    // kept sorted with unused entries last, so the last cell tells fullness
    assign o_full     = w_cell[FREE_SLOTS-1].used;
    assign o_merged   = |w_mrg;

endmodule
`default_nettype wire

/* src/first_fit_lease_allocator_core.sv */
// channel  direction  handshake                  payload
// in       input      i_in_valid / o_in_ready    i_in_data  (fla_pkg::t_in)
// out      output     o_out_valid / i_out_ready  o_out_data (fla_pkg::t_out)
//
// one item at a time. request: searches the lease slots for a free one, then scans
// the sorted free chain for the first fit, then runs the sort rounds; when nothing fits,
// the chain is coalesced (merge sweeps repeated until no merge) and scanned once more.
// tick: visits every lease slot; each expired lease returns its range to the chain,
// with a coalesce first when the free chain is full. the output register is loaded last.
// reset is synchronous and loads the free chain at once, no clearing pass.
// a new beat is taken while the previous result still waits in the output register.
`default_nettype none
module first_fit_lease_allocator_core #(
    parameter int LEASE_SLOTS = fla_pkg::LEASE_SLOTS_DEF,
    parameter int FREE_SLOTS  = fla_pkg::FREE_SLOTS_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  fla_pkg::t_in  i_in_data,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output fla_pkg::t_out o_out_data
);
    import fla_pkg::*;

    localparam int LIDX_W = $clog2(LEASE_SLOTS);
    localparam int FIDX_W = $clog2(FREE_SLOTS);

    typedef enum logic [3:0] {
        S_IDLE,
        S_SLOT,
        S_SCAN,
        S_MRG_E,
        S_MRG_O,
        S_MRG_CHK,
        S_SORT,
        S_TICK,
        S_GIVE,
        S_TNEXT,
        S_FIN
    } t_state;

    t_state              r_state;
    t_state              r_sort_ret;
    t_state              r_co_ret;
    logic [SIZE_W-1:0]   r_size;
    logic [LEASE_W-1:0]  r_len;
    logic [LIDX_W-1:0]   r_lidx;
    logic [LIDX_W-1:0]   r_slot;
    logic [FIDX_W-1:0]   r_fidx;
    logic [FIDX_W-1:0]   r_round;
    logic                r_retry;
    logic                r_co_done;
    logic                r_any_mrg;
    logic                r_granted;
    logic [BASE_W-1:0]   r_start;
    logic [EXP_W-1:0]    r_expired;
    logic [TALLY_W-1:0]  r_req_tally;
    logic [TALLY_W-1:0]  r_grant_tally;
    logic [TALLY_W-1:0]  r_deny_tally;
    logic                r_out_valid;
    t_out                r_out;

    logic [BASE_W-1:0]   r_lease_base [LEASE_SLOTS];
    logic [LEN_W-1:0]    r_lease_span [LEASE_SLOTS];
    logic [LEASE_W-1:0]  r_lease_left [LEASE_SLOTS];
    logic [LEASE_SLOTS-1:0] r_lease_used;

    t_cell_ctl           w_ctl;
    logic                w_wr_en;
    logic [FIDX_W-1:0]   w_wr_idx;
    t_range              w_wr_entry;
    t_range              w_rd;
    logic                w_full;
    logic                w_merged;
    logic                w_fit;
    logic [LEN_W-1:0]    w_rest;
    t_range              w_alloc;
    logic                w_last_lease;
    logic                w_expire;

    fla_free_table #(
        .FREE_SLOTS (FREE_SLOTS)
    ) u_table (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (w_ctl),
        .i_wr_en    (w_wr_en),
        .i_wr_idx   (w_wr_idx),
        .i_wr_entry (w_wr_entry),
        .i_rd_idx   (r_fidx),
        .o_rd_entry (w_rd),
        .o_full     (w_full),
        .o_merged   (w_merged)
    );

    always_comb begin
        w_fit   = w_rd.used && (CMP_W'(w_rd.len) >= CMP_W'(r_size));
        w_rest  = w_rd.len - LEN_W'(r_size);
        if (w_rest == '0) begin
            w_alloc = RANGE_HOLE;
        end else begin
            w_alloc = '{used: 1'b1, base: w_rd.base + BASE_W'(r_size), len: w_rest};
        end
        w_last_lease = (r_lidx == LIDX_W'(LEASE_SLOTS - 1));
        w_expire     = r_lease_used[r_lidx] && (r_lease_left[r_lidx] <= LEASE_W'(1));

        w_ctl = '{op: CELL_HOLD, phase: 1'b0};
        case (r_state)
            S_SORT:  w_ctl = '{op: CELL_SORT, phase: r_round[0]};
            S_MRG_E: w_ctl = '{op: CELL_MERGE, phase: 1'b0};
            S_MRG_O: w_ctl = '{op: CELL_MERGE, phase: 1'b1};
            default: w_ctl = '{op: CELL_HOLD, phase: 1'b0};
        endcase

        w_wr_en    = 1'b0;
        w_wr_idx   = r_fidx;
        w_wr_entry = w_alloc;
        if (r_state == S_SCAN && w_fit) begin
            w_wr_en = 1'b1;
        end else if (r_state == S_GIVE && !w_full) begin
            // returned range goes into the last cell and sorts into place
            w_wr_en    = 1'b1;
            w_wr_idx   = FIDX_W'(FREE_SLOTS - 1);
            w_wr_entry = '{used: 1'b1, base: r_lease_base[r_lidx],
                           len: r_lease_span[r_lidx]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_out_valid   <= 1'b0;
            r_req_tally   <= '0;
            r_grant_tally <= '0;
            r_deny_tally  <= '0;
            r_lease_used  <= '0;
        end else begin
            if (r_state == S_FIN && (!r_out_valid || i_out_ready)) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_size    <= i_in_data.request_size;
                        r_len     <= i_in_data.lease_length;
                        r_granted <= 1'b0;
                        r_start   <= '0;
                        r_expired <= '0;
                        r_lidx    <= '0;
                        if (i_in_data.operation == OP_REQUEST) begin
                            r_req_tally <= sat_inc(r_req_tally);
                            r_state     <= S_SLOT;
                        end else begin
                            r_state <= S_TICK;
                        end
                    end
                end
                S_SLOT: begin
                    if (!r_lease_used[r_lidx]) begin
                        r_slot <= r_lidx;
                        if (r_size == '0) begin
                            r_deny_tally <= sat_inc(r_deny_tally);
                            r_state      <= S_FIN;
                        end else begin
                            r_fidx  <= '0;
                            r_retry <= 1'b0;
                            r_state <= S_SCAN;
                        end
                    end else if (w_last_lease) begin
                        r_deny_tally <= sat_inc(r_deny_tally);
                        r_state      <= S_FIN;
                    end else begin
                        r_lidx <= r_lidx + LIDX_W'(1);
                    end
                end
                S_SCAN: begin
                    if (w_fit) begin
                        r_granted            <= 1'b1;
                        r_start              <= w_rd.base;
                        r_grant_tally        <= sat_inc(r_grant_tally);
                        r_lease_used[r_slot] <= 1'b1;
                        r_round              <= '0;
                        r_sort_ret           <= S_FIN;
                        r_state              <= S_SORT;
                    end else if (!w_rd.used || r_fidx == FIDX_W'(FREE_SLOTS - 1)) begin
                        if (r_retry) begin
                            r_deny_tally <= sat_inc(r_deny_tally);
                            r_state      <= S_FIN;
                        end else begin
                            r_retry  <= 1'b1;
                            r_fidx   <= '0;
                            r_co_ret <= S_SCAN;
                            r_state  <= S_MRG_E;
                        end
                    end else begin
                        r_fidx <= r_fidx + FIDX_W'(1);
                    end
                end
                S_MRG_E: begin
                    r_any_mrg <= w_merged;
                    r_state   <= S_MRG_O;
                end
                S_MRG_O: begin
                    r_any_mrg  <= r_any_mrg | w_merged;
                    r_round    <= '0;
                    r_sort_ret <= S_MRG_CHK;
                    r_state    <= S_SORT;
                end
                S_MRG_CHK: begin
                    // stop once a sweep over every neighbor pair merged nothing
                    r_state <= r_any_mrg ? S_MRG_E : r_co_ret;
                end
                S_SORT: begin
                    if (r_round == FIDX_W'(FREE_SLOTS - 1)) begin
                        r_state <= r_sort_ret;
                    end else begin
                        r_round <= r_round + FIDX_W'(1);
                    end
                end
                S_TICK: begin
                    if (w_expire) begin
                        r_lease_used[r_lidx] <= 1'b0;
                        if (r_expired != '1) begin
                            r_expired <= r_expired + EXP_W'(1);
                        end
                        r_co_done <= 1'b0;
                        r_state   <= S_GIVE;
                    end else if (w_last_lease) begin
                        r_state <= S_FIN;
                    end else begin
                        r_lidx <= r_lidx + LIDX_W'(1);
                    end
                end
                S_GIVE: begin
                    if (!w_full) begin
                        r_round    <= '0;
                        r_sort_ret <= S_TNEXT;
                        r_state    <= S_SORT;
                    end else if (!r_co_done) begin
                        r_co_done <= 1'b1;
                        r_co_ret  <= S_GIVE;
                        r_state   <= S_MRG_E;
                    end else begin
                        // still full after coalescing: the range is dropped
                        r_state <= S_TNEXT;
                    end
                end
                S_TNEXT: begin
                    if (w_last_lease) begin
                        r_state <= S_FIN;
                    end else begin
                        r_lidx  <= r_lidx + LIDX_W'(1);
                        r_state <= S_TICK;
                    end
                end
                S_FIN: begin
                    if (!r_out_valid || i_out_ready) begin
                        r_out.granted           <= r_granted;
                        r_out.start_address     <= ADDR_W'(r_start);
                        r_out.expired_count     <= r_expired;
                        r_out.request_total     <= r_req_tally;
                        r_out.satisfied_total   <= r_grant_tally;
                        r_out.unsatisfied_total <= r_deny_tally;
                        r_state                 <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_SCAN && w_fit) begin
            r_lease_base[r_slot] <= w_rd.base;
            r_lease_span[r_slot] <= LEN_W'(r_size);
            r_lease_left[r_slot] <= r_len;
        end
        if (r_state == S_TICK && r_lease_used[r_lidx] && !w_expire) begin
            r_lease_left[r_lidx] <= r_lease_left[r_lidx] - LEASE_W'(1);
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

`ifndef SYNTH
    a_one_beat_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("second input beat taken while one is in progress");

    a_grant_counted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.granted) |-> (o_out_data.satisfied_total != '0))
        else $error("grant shown without a granted total");

    a_tick_no_grant: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.expired_count != '0)
        |-> (!o_out_data.granted && o_out_data.start_address == '0))
        else $error("expiry reported on a granted beat");
`endif

endmodule
`default_nettype wire

/* tb/tb_checker.sv */
`timescale 1ns / 100ps
`default_nettype none
module tb_checker (
    input  wire           i_clk,
    input  wire           i_rst_n,
    input  wire           i_in_valid,
    input  wire           i_in_ready,
    input  fla_pkg::t_in  i_in_data,
    input  wire           i_out_valid,
    input  wire           i_out_ready,
    input  fla_pkg::t_out i_out_data,
    output int            o_fail_count,
    output int            o_pending
);
    import fla_pkg::*;

    localparam int NLEASE = 16;
    localparam int NFREE  = 17;

    // allocator image
    int unsigned fr_base [NFREE];
    int unsigned fr_len  [NFREE];
    bit          fr_used [NFREE];
    int unsigned ls_base [NLEASE];
    int unsigned ls_span [NLEASE];
    int unsigned ls_left [NLEASE];
    bit          ls_used [NLEASE];
    logic [TALLY_W-1:0] cnt_req, cnt_grant, cnt_deny;

    t_out expected_results[$];

    function automatic logic [TALLY_W-1:0] bump(input logic [TALLY_W-1:0] v);
        return (v == '1) ? v : v + 1'b1;
    endfunction

    task automatic merge_ranges();
        bit changed;
        changed = 1;
        while (changed) begin
            changed = 0;
            for (int a = 0; a < NFREE; a++) begin
                if (!fr_used[a]) continue;
                for (int b = 0; b < NFREE; b++) begin
                    if (b == a || !fr_used[b]) continue;
                    if (fr_base[a] + fr_len[a] == fr_base[b]) begin
                        fr_len[a] += fr_len[b];
                        fr_used[b] = 0;
                        fr_base[b] = 0;
                        fr_len[b] = 0;
                        changed = 1;
                    end
                end
            end
        end
    endtask

    function automatic int lowest_fit(input int unsigned size);
        int best;
        best = -1;
        for (int i = 0; i < NFREE; i++)
            if (fr_used[i] && fr_len[i] >= size && (best < 0 || fr_base[i] < fr_base[best]))
                best = i;
        return best;
    endfunction

    function automatic int empty_range();
        for (int i = 0; i < NFREE; i++)
            if (!fr_used[i]) return i;
        return -1;
    endfunction

    task automatic return_range(input int unsigned base, input int unsigned span);
        int k;
        k = empty_range();
        if (k < 0) begin
            merge_ranges();
            k = empty_range();
        end
        if (k >= 0) begin
            fr_used[k] = 1;
            fr_base[k] = base;
            fr_len[k] = span;
        end
    endtask

    task automatic predict_allocation(input t_in item);
        t_out res;
        int slot, f;
        int unsigned size, expired, start;
        res = '0;
        expired = 0;
        start = 0;
        if (item.operation == OP_TICK) begin
            for (int s = 0; s < NLEASE; s++) begin
                if (!ls_used[s]) continue;
                if (ls_left[s] <= 1) begin
                    ls_used[s] = 0;
                    ls_left[s] = 0;
                    return_range(ls_base[s], ls_span[s]);
                    if (expired < 31) expired++;
                end else begin
                    ls_left[s]--;
                end
            end
        end else begin
            size = item.request_size;
            slot = -1;
            cnt_req = bump(cnt_req);
            for (int s = 0; s < NLEASE; s++)
                if (!ls_used[s]) begin
                    slot = s;
                    break;
                end
            if (size != 0 && slot >= 0) begin
                f = lowest_fit(size);
                if (f < 0) begin
                    merge_ranges();
                    f = lowest_fit(size);
                end
                if (f >= 0) begin
                    start = fr_base[f];
                    fr_base[f] += size;
                    fr_len[f] -= size;
                    if (fr_len[f] == 0) begin
                        fr_used[f] = 0;
                        fr_base[f] = 0;
                    end
                    ls_used[slot] = 1;
                    ls_base[slot] = start;
                    ls_span[slot] = size;
                    ls_left[slot] = item.lease_length;
                    res.granted = 1'b1;
                end
            end
            if (res.granted) cnt_grant = bump(cnt_grant);
            else cnt_deny = bump(cnt_deny);
        end
        res.start_address = start[ADDR_W-1:0];
        res.expired_count = expired[EXP_W-1:0];
        res.request_total = cnt_req;
        res.satisfied_total = cnt_grant;
        res.unsatisfied_total = cnt_deny;
        expected_results = {expected_results, res};
    endtask

    assign o_pending = expected_results.size();

    always @(posedge i_clk) begin
        t_out want;
        if (!i_rst_n) begin
            for (int i = 0; i < NFREE; i++) begin
                fr_base[i] = 0;
                fr_len[i] = 0;
                fr_used[i] = 0;
            end
            for (int i = 0; i < NLEASE; i++) ls_used[i] = 0;
            fr_len[0] = MEM_UNITS;
            fr_used[0] = 1;
            cnt_req = '0;
            cnt_grant = '0;
            cnt_deny = '0;
            expected_results.delete();
            o_fail_count <= 0;
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (expected_results.size() == 0) begin
                    if (o_fail_count < 10)
                        $display("unexpected result beat %p", i_out_data);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    want = expected_results.pop_front();
                    if (want !== i_out_data) begin
                        if (o_fail_count < 10)
                            $display("mismatch: expected %p, got %p", want, i_out_data);
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
            if (i_in_valid && i_in_ready) predict_allocation(i_in_data);
        end
    end
endmodule
`default_nettype wire

/* tb/tb_top.sv */
`timescale 1ns / 100ps
`default_nettype none
module tb_top;
    import fla_pkg::*;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_ready;
    t_in  in_data = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    t_out out_data;
    int   fail_count;
    int   pending;
    int   idle_cycles = 0;
    bit   long_hold = 0;

    always #10 i_clk = ~i_clk;

    first_fit_lease_allocator_core u_top (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(in_valid), .o_in_ready(in_ready), .i_in_data(in_data),
        .o_out_valid(out_valid), .i_out_ready(out_ready), .o_out_data(out_data)
    );

    tb_checker u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(in_valid), .i_in_ready(in_ready), .i_in_data(in_data),
        .i_out_valid(out_valid), .i_out_ready(out_ready), .i_out_data(out_data),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    function automatic t_in rand_item();
        t_in it;
        int pick;
        it.operation = ($urandom_range(0, 99) < 65) ? OP_REQUEST : OP_TICK;
        pick = $urandom_range(0, 99);
        if (pick < 60) it.request_size = SIZE_W'($urandom_range(1, 64));
        else if (pick < 85) it.request_size = SIZE_W'($urandom_range(65, 400));
        else if (pick < 95) it.request_size = SIZE_W'($urandom_range(401, 1024));
        else it.request_size = SIZE_W'($urandom_range(0, 2047));
        pick = $urandom_range(0, 99);
        if (pick < 70) it.lease_length = LEASE_W'($urandom_range(1, 8));
        else it.lease_length = LEASE_W'($urandom_range(0, 255));
        return it;
    endfunction

    task automatic send_item(input t_in it);
        in_valid <= 1'b1;
        in_data <= it;
        @(posedge i_clk);
        while (!in_ready) @(posedge i_clk);
    endtask

    task automatic send_gap();
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge i_clk);
    endtask

    function automatic t_in mk(input logic op, input int sz, input int ln);
        t_in it;
        it.operation = op;
        it.request_size = SIZE_W'(sz);
        it.lease_length = LEASE_W'(ln);
        return it;
    endfunction

    // receiver: random stall pattern, one long hold-off
    always @(posedge i_clk) begin
        if (long_hold) out_ready <= 1'b0;
        else out_ready <= ($urandom_range(0, 3) != 0);
    end

    initial begin
        repeat (300) @(posedge i_clk);
        long_hold = 1;
        repeat (2000) @(posedge i_clk);
        long_hold = 0;
    end

    // watchdog on cycles with no accepted beat
    always @(posedge i_clk) begin
        if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles > 20000 && !long_hold) begin
            $display("** first_fit_lease_allocator_core: FAILED **");
            $finish;
        end
    end

    initial begin
        int n;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        // directed: extremes and special cases
        send_item(mk(OP_REQUEST, 0, 5));
        send_item(mk(OP_REQUEST, 2047, 255));
        send_item(mk(OP_REQUEST, 1025, 1));
        send_item(mk(OP_REQUEST, 1024, 0));
        send_item(mk(OP_REQUEST, 1, 1));
        send_item(mk(OP_TICK, 2047, 255));
        send_item(mk(OP_TICK, 0, 0));
        for (int i = 0; i < 17; i++) send_item(mk(OP_REQUEST, 1 + (i % 3), 1 + (i % 2)));
        send_item(mk(OP_TICK, 1365, 170));
        send_item(mk(OP_TICK, 682, 85));
        // pause until every result has come back
        in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        // many small leases with staggered expiry to fragment the free table
        for (int i = 0; i < 16; i++) send_item(mk(OP_REQUEST, 64, 1 + (i % 2) * 2));
        send_item(mk(OP_TICK, 0, 0));
        send_item(mk(OP_REQUEST, 100, 1));
        n = 0;
        while (n < 600) begin
            for (int b = $urandom_range(1, 20); b > 0 && n < 600; b--) begin
                send_item(rand_item());
                n++;
            end
            if ($urandom_range(0, 2) != 0) send_gap();
        end
        in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
        if (fail_count == 0) $display("** first_fit_lease_allocator_core: PASSED **");
        else $display("** first_fit_lease_allocator_core: FAILED **");
        $finish;
    end
endmodule
`default_nettype wire

/* sim.f */
src/fla_pkg.sv
src/fla_free_cell.sv
src/fla_free_table.sv
src/first_fit_lease_allocator_core.sv
tb/tb_checker.sv
tb/tb_top.sv
